/* rtl/crct_pkg.sv */
// shared constants, register indexes and chain tag type for the crosswise repetition count test
package crct_pkg;

	localparam int MAX_BITS_DEF = 8;
	localparam int RUN_BITS_DEF = 16;

	localparam int SYM_W  = 8;
	localparam int AB_W   = 4;
	localparam int CUT_W  = 16;
	localparam int LIT_W  = 4;
	localparam int CRS_W  = 5;
	localparam int IDX_W  = 2;
	localparam int DATA_W = 16;

	localparam logic [AB_W-1:0]  ACTIVE_BITS_RST = 4'd8;
	localparam logic [CUT_W-1:0] CUTOFF_RST      = 16'd0;

	typedef enum logic [IDX_W-1:0] {
		REG_ACTIVE_BITS    = 2'd0,
		REG_LITERAL_CUTOFF = 2'd1,
		REG_CROSS_CUTOFF   = 2'd2
	} cfg_reg_t;

	// travels with each symbol along the chain of cells
	typedef struct packed {
		logic             first;
		logic [LIT_W-1:0] lit;
		logic [CRS_W-1:0] crs;
	} item_tag_t;

endpackage

/* rtl/crct_cell.sv */
// one cell of the chain: literal test of bit IDX and cross tests of IDX against every lower bit
module crct_cell import crct_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF,
	parameter int RUN_BITS = RUN_BITS_DEF,
	parameter int IDX      = 0,
	parameter int NB_W     = $clog2(MAX_BITS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [NB_W-1:0]     n_eff,
	input  logic [CUT_W-1:0]    literal_cutoff,
	input  logic [CUT_W-1:0]    cross_cutoff,
	input  logic                valid_in,
	input  logic [MAX_BITS-1:0] bits_in,
	input  item_tag_t           tag_in,
	output logic                valid_out,
	output logic [MAX_BITS-1:0] bits_out,
	output item_tag_t           tag_out
);

	localparam int NT = IDX + 1;
	localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
	localparam logic [RUN_BITS-1:0] RUN_ONE = RUN_BITS'(1);

	logic                ref_q [NT];
	logic [RUN_BITS-1:0] run_q [NT];

	logic                v_c   [NT];
	logic [RUN_BITS-1:0] run_c [NT];
	logic [NT-1:0]       fail_c;
	logic [CRS_W-1:0]    crs_cnt;
	logic                active;
	logic                take;
	item_tag_t           tag_nx;

	logic                valid_s1;
	logic [MAX_BITS-1:0] bits_s1;
	item_tag_t           tag_s1;

	assign active = 32'(n_eff) > IDX;
	assign take   = en && valid_in && active;

	always_comb begin
		for (int j = 0; j < NT; j++) begin
			v_c[j]    = (j == IDX) ? bits_in[IDX] : (bits_in[IDX] ^ bits_in[j]);
			run_c[j]  = RUN_ONE;
			fail_c[j] = 1'b0;
			if (!tag_in.first && (v_c[j] == ref_q[j])) begin
				run_c[j]  = (run_q[j] == RUN_MAX) ? run_q[j] : run_q[j] + RUN_ONE;
				fail_c[j] = 32'(run_c[j]) >=
					32'((j == IDX) ? literal_cutoff : cross_cutoff);
			end
		end
	end

	always_comb begin
		crs_cnt = '0;
		for (int j = 0; j < IDX; j++) begin
			crs_cnt = crs_cnt + CRS_W'(fail_c[j]);
		end
	end

	// counts only grow in cells whose bit is in use
	always_comb begin
		tag_nx = tag_in;
		if (active) begin
			tag_nx.lit = tag_in.lit + LIT_W'(fail_c[IDX]);
			tag_nx.crs = tag_in.crs + crs_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NT; j++) begin
				ref_q[j] <= 1'b0;
				run_q[j] <= '0;
			end
		end else if (take) begin
			for (int j = 0; j < NT; j++) begin
				ref_q[j] <= v_c[j];
				run_q[j] <= run_c[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bits_s1 <= bits_in;
			tag_s1  <= tag_nx;
		end
	end

	assign valid_out = valid_s1;
	assign bits_out  = bits_s1;
	assign tag_out   = tag_s1;

endmodule

/* rtl/crosswise_repetition_count_test_core.sv */
// top level of the crosswise repetition count test: chain of cells, result register, config
//
// usage
//   input channel: symbol with in_valid / in_stall, one oscillator copy per bit.
//   output channel: pass, literal_fails, cross_fails, max_literal_fails and
//   max_cross_fails with out_valid / out_stall, one result per symbol, in order.
//   a transfer happens on a rising edge with valid high and stall low.
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 active_bits, 1 literal_cutoff, 2 cross_cutoff, index 3 ignored.
//   cfg_ready is always high; write only while no symbol is in flight.
// timing
//   a symbol walks through the MAX_BITS registered cells, then the result
//   register.
//   one symbol per cycle sustained while no result waits under out_stall;
//   each cell updates its own tests when the symbol reaches it.
// reset
//   all run lengths and previous bits clear, the first symbol after reset
//   only loads the tests; peaks clear; registers return to 8, 0, 0.
// stall
//   the whole chain freezes while a result waits under out_stall; in_stall
//   rises in the same cycle so no symbol is taken until the result leaves.
module crosswise_repetition_count_test_core import crct_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF,
	parameter int RUN_BITS = RUN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [SYM_W-1:0]  symbol,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              pass,
	output logic [LIT_W-1:0]  literal_fails,
	output logic [CRS_W-1:0]  cross_fails,
	output logic [LIT_W-1:0]  max_literal_fails,
	output logic [CRS_W-1:0]  max_cross_fails,
	// config channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	localparam int NB_W = $clog2(MAX_BITS + 1);

	// configuration registers
	logic [AB_W-1:0]  active_bits_q;
	logic [CUT_W-1:0] literal_cutoff_q;
	logic [CUT_W-1:0] cross_cutoff_q;
	logic [NB_W-1:0]  n_eff;

	// chain links, index 0 is the input side
	logic                valid_c [MAX_BITS+1];
	logic [MAX_BITS-1:0] bits_c  [MAX_BITS+1];
	item_tag_t           tag_c   [MAX_BITS+1];

	logic             seen_q;
	logic             adv;
	logic             out_valid_q;
	logic             pass_q;
	logic [LIT_W-1:0] lit_q;
	logic [CRS_W-1:0] crs_q;
	logic [LIT_W-1:0] peak_lit_q;
	logic [CRS_W-1:0] peak_crs_q;
	item_tag_t        last_tag;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bits_q    <= ACTIVE_BITS_RST;
			literal_cutoff_q <= CUTOFF_RST;
			cross_cutoff_q   <= CUTOFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE_BITS:    active_bits_q    <= cfg_data[AB_W-1:0];
				REG_LITERAL_CUTOFF: literal_cutoff_q <= cfg_data[CUT_W-1:0];
				REG_CROSS_CUTOFF:   cross_cutoff_q   <= cfg_data[CUT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero counts as one copy, anything beyond the chain length as all copies
	always_comb begin
		if (active_bits_q == '0) begin
			n_eff = NB_W'(1);
		end else if (32'(active_bits_q) > MAX_BITS) begin
			n_eff = NB_W'(MAX_BITS);
		end else begin
			n_eff = NB_W'(active_bits_q);
		end
	end

	// chain moves whenever the result register is free or being emptied
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (in_valid && adv) begin
			seen_q <= 1'b1;
		end
	end

	// symbol bits above the input width read as zero
	for (genvar k = 0; k < MAX_BITS; k++) begin : g_sym
		if (k < SYM_W) begin : g_in
			assign bits_c[0][k] = symbol[k];
		end else begin : g_zero
			assign bits_c[0][k] = 1'b0;
		end
	end

	assign valid_c[0]     = in_valid;
	assign tag_c[0].first = !seen_q;
	assign tag_c[0].lit   = '0;
	assign tag_c[0].crs   = '0;

	for (genvar i = 0; i < MAX_BITS; i++) begin : g_cell
		crct_cell #(
			.MAX_BITS (MAX_BITS),
			.RUN_BITS (RUN_BITS),
			.IDX      (i),
			.NB_W     (NB_W)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.en             (adv),
			.n_eff          (n_eff),
			.literal_cutoff (literal_cutoff_q),
			.cross_cutoff   (cross_cutoff_q),
			.valid_in       (valid_c[i]),
			.bits_in        (bits_c[i]),
			.tag_in         (tag_c[i]),
			.valid_out      (valid_c[i+1]),
			.bits_out       (bits_c[i+1]),
			.tag_out        (tag_c[i+1])
		);
	end

	assign last_tag = tag_c[MAX_BITS];

	// result register and running peaks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			peak_lit_q  <= '0;
			peak_crs_q  <= '0;
		end else if (adv) begin
			out_valid_q <= valid_c[MAX_BITS];
			if (valid_c[MAX_BITS]) begin
				if (last_tag.lit > peak_lit_q) begin
					peak_lit_q <= last_tag.lit;
				end
				if (last_tag.crs > peak_crs_q) begin
					peak_crs_q <= last_tag.crs;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_c[MAX_BITS]) begin
			pass_q <= (last_tag.lit == '0) && (last_tag.crs == '0);
			lit_q  <= last_tag.lit;
			crs_q  <= last_tag.crs;
		end
	end

	assign out_valid         = out_valid_q;
	assign pass              = pass_q;
	assign literal_fails     = lit_q;
	assign cross_fails       = crs_q;
	assign max_literal_fails = peak_lit_q;
	assign max_cross_fails   = peak_crs_q;

	// pass flag agrees with both counts
	a_pass_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pass == ((literal_fails == '0) && (cross_fails == '0))))
		else $error("pass disagrees with failure counts");

	// peaks cover the counts they are shown with
	a_peak_cover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((max_literal_fails >= literal_fails) &&
			(max_cross_fails >= cross_fails)))
		else $error("peak below current failure count");

	// peaks never fall
	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((peak_lit_q >= $past(peak_lit_q)) && (peak_crs_q >= $past(peak_crs_q))))
		else $error("peak decreased");

	// a held result keeps the whole chain frozen
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(peak_lit_q) && $stable(peak_crs_q) && out_valid))
		else $error("chain moved under a stalled result");

endmodule
